### design/ekvt_pkg.sv
// ----------------------------------------------------------------------------
// ekvt_pkg
// Shared sizes, opcodes, state codes and controller/datapath interface types
// for the expiring key/value table.
// ----------------------------------------------------------------------------
package ekvt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int OPCODE_W  = 2;
   localparam int TIME_W    = 47;
   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int LIFE_W    = 31;
   localparam int EXPIRY_W  = 48;
   localparam int COUNT_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // one slot in the store: key low, then value, then expiry
   localparam int SLOT_W = KEY_W + VALUE_W + EXPIRY_W;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SET   = 2'd0,
      OP_GET   = 2'd1,
      OP_COUNT = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic rd_last;
      logic rsp_busy;
   } stat_type;

endpackage

### design/ekvt_ram.sv
// ----------------------------------------------------------------------------
// ekvt_ram
// Generic single-port RAM, one read or write a cycle, registered read data.
// ----------------------------------------------------------------------------
module ekvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ekvt_datapath.sv
// ----------------------------------------------------------------------------
// ekvt_datapath
// Request capture, slot scan with key match, free slot and live count
// tracking, valid marks, slot store and the result register.
// ----------------------------------------------------------------------------
module ekvt_datapath
   import ekvt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output stat_type              stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OPCODE_W-1:0]   req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // captured item
   opcode_type         op_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [LIFE_W-1:0]  life_ff;

   // scan pipeline
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] eval_idx_ff;

   // scan findings
   logic               match_found_ff, match_found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               match_live_ff, match_live_in;
   logic [VALUE_W-1:0] match_value_ff, match_value_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // store port
   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [SLOT_W-1:0] ram_wdata;
   logic [SLOT_W-1:0] ram_rdata;

   logic [KEY_W-1:0]    rd_key;
   logic [VALUE_W-1:0]  rd_value;
   logic [EXPIRY_W-1:0] rd_expiry;
   logic                rd_valid;
   logic                rd_live;
   logic                rd_match;

   logic               set_slot_ok;
   logic [IDX_W-1:0]   set_slot;
   logic               hit;
   logic [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0] live_count;
   logic               table_full;

   assign rd_key    = ram_rdata[KEY_W-1:0];
   assign rd_value  = ram_rdata[KEY_W+VALUE_W-1:KEY_W];
   assign rd_expiry = ram_rdata[SLOT_W-1:KEY_W+VALUE_W];
   assign rd_valid  = valid_ff[eval_idx_ff];
   assign rd_live   = rd_valid && (rd_expiry > {1'b0, now_ff});
   assign rd_match  = rd_valid && (rd_key == key_ff);

   assign set_slot_ok = match_found_ff || free_found_ff;
   assign set_slot    = match_found_ff ? match_idx_ff : free_idx_ff;

   assign ram_we    = ctrl.commit && (op_ff == OP_SET) && set_slot_ok;
   assign ram_addr  = ctrl.commit ? set_slot : addr_ff;
   assign ram_wdata = {{1'b0, now_ff} + {{(EXPIRY_W-LIFE_W){1'b0}}, life_ff}, val_ff, key_ff};

   ekvt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // result fields of the item being committed
   always_comb begin
      hit        = 1'b0;
      read_value = '0;
      live_count = '0;
      table_full = 1'b0;
      unique case (op_ff)
         OP_SET: begin
            hit        = match_found_ff && match_live_ff;
            table_full = !set_slot_ok;
         end
         OP_GET: begin
            hit        = match_found_ff && match_live_ff;
            read_value = hit ? match_value_ff : '1;
         end
         OP_COUNT: begin
            live_count = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      addr_in        = addr_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_live_in  = match_live_ff;
      match_value_in = match_value_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      valid_in       = valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (ctrl.load) begin
         addr_in        = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         count_in       = '0;
      end
      if (ctrl.rd_en) begin
         addr_in = addr_ff + 1'b1;
      end

      // data for slot eval_idx_ff is back from the store
      if (rd_vld_ff) begin
         if (rd_match && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = eval_idx_ff;
            match_live_in  = rd_live;
            match_value_in = rd_value;
         end
         if (!rd_live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = eval_idx_ff;
         end
         if (op_ff == OP_COUNT) begin
            if (rd_live && count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (rd_valid && !rd_live) begin
               valid_in[eval_idx_ff] = 1'b0;
            end
         end
      end

      if (ctrl.commit) begin
         if (op_ff == OP_SET && set_slot_ok) begin
            valid_in[set_slot] = 1'b1;
         end
         // expired match found by a get is dropped
         if (op_ff == OP_GET && match_found_ff && !match_live_ff) begin
            valid_in[match_idx_ff] = 1'b0;
         end
         rsp_data_in  = {{(RSP_DATA_W-39){1'b0}}, table_full, live_count, read_value, hit};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff   <= opcode_type'(req_tuser);
         now_ff  <= req_tdata[46:0];
         key_ff  <= req_tdata[78:47];
         val_ff  <= req_tdata[110:79];
         life_ff <= req_tdata[141:111];
      end
      addr_ff        <= addr_in;
      eval_idx_ff    <= addr_ff;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_live_ff  <= match_live_in;
      match_value_ff <= match_value_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      count_ff       <= count_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= ctrl.rd_en;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.rd_last  = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign stat.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/ekvt_ctrl.sv
// ----------------------------------------------------------------------------
// ekvt_ctrl
// Sequencer: accepts an item, sweeps the slots, waits for the last compare,
// then commits the update and the result.
// ----------------------------------------------------------------------------
module ekvt_ctrl
   import ekvt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      ctrl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.rd_en = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register can take the item
            if (!stat.rsp_busy) begin
               ctrl.commit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/expiring_key_value_table.sv
// Sequence: accept the item, sweep every slot, drain the last compare, then commit; the result
// is registered at the commit. One item at a time: no new item is taken until the commit, as
// the sweep runs sequentially over the single-port slot store, one slot read per cycle.
// A waiting result stalls the commit step, and with it the acceptance of the next item.
// Reset: synchronous, clears all valid marks, the sequencer and the result valid flag;
// slot contents are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// expiring_key_value_table
// Associative table of key, value and expiry time with set, get and count.
// ----------------------------------------------------------------------------
module expiring_key_value_table
   import ekvt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_time[46:0], lookup_key[78:47], new_value[110:79], lifetime[141:111], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit[0], read_value[32:1], live_count[37:33], table_full[38], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   ctrl_type ctrl;
   stat_type stat;

   ekvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   ekvt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // one item at a time: no second accept right after one
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while one is in flight");

   // a dropped set never reports a hit
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[38]))
      else $error("table_full together with hit");

   // a result with a nonzero live count carries no set or get flags
   a_count_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[37:33] != 5'd0) |-> (!rsp_tdata[0] && !rsp_tdata[38]))
      else $error("count result with hit or full");

   // commit never overlaps scan or load; the store is written only in the commit step
   a_commit_only: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> !ctrl.rd_en && !ctrl.load)
      else $error("commit overlaps scan or load");

endmodule
